// ----- hw/rtl/lcdt_pkg.sv -----
// Shared constants, codes and types of the display line timing block.
`timescale 1ns / 1ps
`default_nettype none

package lcdt_pkg;

   localparam int OAM_ENTRIES_DEF      = 40;
   localparam int MAX_LINE_SPRITES_DEF = 10;
   localparam int DOTS_PER_LINE_DEF    = 456;
   localparam int VISIBLE_LINES_DEF    = 144;
   localparam int FRAME_LINES_DEF      = 154;
   localparam int SCAN_DOTS_DEF        = 80;

   localparam int RESULT_CAP  = 11;
   localparam int SPRITE_DOTS = 6;
   localparam int PENALTY_MAX = 63;
   localparam int Y_OFFSET    = 16;
   localparam int ENTRY_W     = 32;

   localparam logic [2:0] CSR_LINE_COMPARE   = 3'd0;
   localparam logic [2:0] CSR_STAT_ON_MATCH  = 3'd1;
   localparam logic [2:0] CSR_STAT_ON_HBLANK = 3'd2;
   localparam logic [2:0] CSR_STAT_ON_VBLANK = 3'd3;
   localparam logic [2:0] CSR_SPRITE_HEIGHT  = 3'd4;
   localparam logic [2:0] CSR_WINDOW_TOP     = 3'd5;

   localparam logic [1:0] MODE_HBLANK = 2'd0;
   localparam logic [1:0] MODE_VBLANK = 2'd1;
   localparam logic [1:0] MODE_SCAN   = 2'd2;
   localparam logic [1:0] MODE_DRAW   = 2'd3;

   localparam logic OP_DOT       = 1'b0;
   localparam logic OP_OAM_WRITE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } lcdt_state_type;

   typedef struct packed {
      logic clear;
      logic load;
   } lcdt_scan_ctl_type;

endpackage

`default_nettype wire

// ----- hw/rtl/lcdt_oam_mem.sv -----
// Object attribute memory: byte-writable, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lcdt_oam_mem #(
   parameter int OAM_ENTRIES = lcdt_pkg::OAM_ENTRIES_DEF,
   parameter int AW = (OAM_ENTRIES > 1) ? $clog2(OAM_ENTRIES) : 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [1:0]                 wr_lane,
   input  wire logic [7:0]                 wr_data,
   input  wire logic [AW-1:0]              rd_addr,
   output logic [lcdt_pkg::ENTRY_W-1:0]    rd_data
);

   logic [lcdt_pkg::ENTRY_W-1:0] mem [OAM_ENTRIES];
   logic [3:0]                   valid_ff [OAM_ENTRIES];
   logic [lcdt_pkg::ENTRY_W-1:0] rd_data_ff;
   logic [3:0]                   rd_mask_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr][wr_lane*8 +: 8] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Bytes never written since reset read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < OAM_ENTRIES; i++) begin
            valid_ff[i] <= 4'b0000;
         end
         rd_mask_ff <= 4'b0000;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr][wr_lane] <= 1'b1;
         end
         rd_mask_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff & {{8{rd_mask_ff[3]}}, {8{rd_mask_ff[2]}},
                                  {8{rd_mask_ff[1]}}, {8{rd_mask_ff[0]}}};

endmodule

`default_nettype wire

// ----- hw/rtl/lcdt_line_sel.sv -----
// Per-line sprite list with X-ordered insertion of matching objects.
`timescale 1ns / 1ps
`default_nettype none

module lcdt_line_sel #(
   parameter int MAX_LINE_SPRITES = lcdt_pkg::MAX_LINE_SPRITES_DEF,
   parameter int CW = $clog2(MAX_LINE_SPRITES + 1),
   parameter int SW = (MAX_LINE_SPRITES > 1) ? $clog2(MAX_LINE_SPRITES) : 1
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire lcdt_pkg::lcdt_scan_ctl_type  ctl,
   input  wire logic [lcdt_pkg::ENTRY_W-1:0] ins_entry,
   input  wire logic [7:0]                   line,
   input  wire logic [4:0]                   height,
   input  wire logic [SW-1:0]                rd_idx,
   output logic [CW-1:0]                     count,
   output logic [lcdt_pkg::ENTRY_W-1:0]      rd_entry
);

   logic [lcdt_pkg::ENTRY_W-1:0] slot_ff [MAX_LINE_SPRITES];
   logic [lcdt_pkg::ENTRY_W-1:0] slot_in [MAX_LINE_SPRITES];
   logic [CW-1:0]                count_ff;
   logic [MAX_LINE_SPRITES-1:0]  le;
   logic [8:0]                   cur;
   logic [9:0]                   bottom;
   logic                         hit;
   logic                         take;

   always_comb begin
      cur    = 9'({1'b0, line}) + 9'(lcdt_pkg::Y_OFFSET);
      bottom = 10'(ins_entry[7:0]) + 10'(height);
      hit    = (9'(ins_entry[7:0]) <= cur) && (bottom > 10'(cur));
      take   = ctl.load && hit && (count_ff < CW'(MAX_LINE_SPRITES));
      for (int j = 0; j < MAX_LINE_SPRITES; j++) begin
         le[j] = (CW'(j) < count_ff) && (slot_ff[j][15:8] <= ins_entry[15:8]);
      end
   end

   // The list is kept sorted, so le is a run of ones from slot 0: slots in that
   // run stay, the first slot past it takes the new entry, the rest move up.
   for (genvar j = 0; j < MAX_LINE_SPRITES; j++) begin : g_slot
      if (j == 0) begin : g_first
         assign slot_in[j] = le[j] ? slot_ff[j] : ins_entry;
      end else begin : g_rest
         assign slot_in[j] = le[j] ? slot_ff[j] : (le[j-1] ? ins_entry : slot_ff[j-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         for (int j = 0; j < MAX_LINE_SPRITES; j++) begin
            slot_ff[j] <= slot_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctl.clear) begin
         count_ff <= '0;
      end else if (take) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   assign count    = count_ff;
   assign rd_entry = slot_ff[rd_idx];

endmodule

`default_nettype wire

// ----- hw/rtl/lcd_mode_timing_with_oam_scan.sv -----
// Top level: display line timing, mode sequencing and per-line sprite scan.
`timescale 1ns / 1ps
`default_nettype none

// Each request is either one dot tick or one byte written into object attribute
// memory, and gives one response, except the dot that moves from OAM scan to
// drawing, which gives one response per selected sprite (at most ten, X order,
// OAM order on ties) with last set on the final one. A plain request's response
// is registered when the request is accepted and can be taken while the following
// request is accepted. The dot that opens a line's OAM scan reads the whole
// object memory through its single synchronous read port, one entry per cycle,
// and its response shows only once every entry has been offered to the sprite
// list. The dot that enters drawing keeps further requests waiting until its last
// sprite response has been taken. Object memory comes out of reset as all zero
// at once, tracked by per-byte valid flags, so no clearing pass is needed.
// Configuration writes are always ready and are meant for idle periods.
module lcd_mode_timing_with_oam_scan #(
   parameter int OAM_ENTRIES      = lcdt_pkg::OAM_ENTRIES_DEF,
   parameter int MAX_LINE_SPRITES = lcdt_pkg::MAX_LINE_SPRITES_DEF,
   parameter int DOTS_PER_LINE    = lcdt_pkg::DOTS_PER_LINE_DEF,
   parameter int VISIBLE_LINES    = lcdt_pkg::VISIBLE_LINES_DEF,
   parameter int FRAME_LINES      = lcdt_pkg::FRAME_LINES_DEF,
   parameter int SCAN_DOTS        = lcdt_pkg::SCAN_DOTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_mode,
   input  wire logic [7:0]  req_oam_index,
   input  wire logic [7:0]  req_oam_data,
   input  wire logic        req_pixels_done,
   input  wire logic        req_window_visible,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_lcd_mode,
   output logic [7:0]       rsp_line_count,
   output logic             rsp_match_flag,
   output logic             rsp_vblank_request,
   output logic             rsp_stat_request,
   output logic             rsp_frame_done,
   output logic [7:0]       rsp_window_line,
   output logic             rsp_sprite_valid,
   output logic [31:0]      rsp_sprite_entry,
   output logic [3:0]       rsp_sprite_count,
   output logic             rsp_last
);

   localparam int AW   = (OAM_ENTRIES > 1) ? $clog2(OAM_ENTRIES) : 1;
   localparam int CW   = $clog2(MAX_LINE_SPRITES + 1);
   localparam int SW   = (MAX_LINE_SPRITES > 1) ? $clog2(MAX_LINE_SPRITES) : 1;
   localparam int NCAP = (MAX_LINE_SPRITES < lcdt_pkg::RESULT_CAP) ?
                         MAX_LINE_SPRITES : lcdt_pkg::RESULT_CAP;

   // Configuration registers.
   logic [7:0] lyc_ff;
   logic       stat_match_ff;
   logic       stat_hblank_ff;
   logic       stat_vblank_ff;
   logic [4:0] height_ff;
   logic [7:0] wtop_ff;

   // Timing state and its next values.
   lcdt_pkg::lcdt_state_type state_ff, state_in;
   logic [8:0]    dot_ff, dot_in;
   logic [1:0]    mode_ff, mode_in;
   logic [7:0]    line_ff, line_in;
   logic          match_ff, match_in;
   logic [7:0]    win_ff, win_in;
   logic [5:0]    pen_ff, pen_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          vb_ff, vb_in;
   logic          st_ff, st_in;
   logic          fd_ff, fd_in;
   logic          spv_ff, spv_in;
   logic          last_ff, last_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [AW:0]   scan_addr_ff, scan_addr_in;
   logic          pend_ff, pend_in;

   // Datapath between the parts.
   logic                         accept;
   logic                         mem_we;
   logic [lcdt_pkg::ENTRY_W-1:0] mem_rdata;
   logic                         issue;
   lcdt_pkg::lcdt_scan_ctl_type  scan_ctl;
   logic [CW-1:0]                sel_count;
   logic [lcdt_pkg::ENTRY_W-1:0] sel_entry;
   logic [CW-1:0]                n_emit;
   logic [7:0]                   pen_full;
   logic [8:0]                   dot_next;
   logic [7:0]                   line_next;
   logic                         win_step;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lyc_ff         <= 8'd0;
         stat_match_ff  <= 1'b0;
         stat_hblank_ff <= 1'b0;
         stat_vblank_ff <= 1'b0;
         height_ff      <= 5'd8;
         wtop_ff        <= 8'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lcdt_pkg::CSR_LINE_COMPARE:   lyc_ff         <= csr_data;
            lcdt_pkg::CSR_STAT_ON_MATCH:  stat_match_ff  <= csr_data[0];
            lcdt_pkg::CSR_STAT_ON_HBLANK: stat_hblank_ff <= csr_data[0];
            lcdt_pkg::CSR_STAT_ON_VBLANK: stat_vblank_ff <= csr_data[0];
            lcdt_pkg::CSR_SPRITE_HEIGHT:  height_ff      <= csr_data[4:0];
            lcdt_pkg::CSR_WINDOW_TOP:     wtop_ff        <= csr_data;
            default: ;
         endcase
      end
   end

   // New requests wait while a scan or a sprite burst runs, and while the
   // response register holds a result that is not being taken.
   assign req_stall = (state_ff != lcdt_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign mem_we = accept && (req_mode == lcdt_pkg::OP_OAM_WRITE) &&
                   (9'(req_oam_index) < 9'(OAM_ENTRIES * 4));

   // During a scan one entry address goes out per cycle; its data comes back in the
   // next cycle and is offered to the sprite list.
   assign issue = (state_ff == lcdt_pkg::ST_SCAN) && (scan_addr_ff < (AW+1)'(OAM_ENTRIES));

   lcdt_oam_mem #(
      .OAM_ENTRIES (OAM_ENTRIES),
      .AW          (AW)
   ) u_oam_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_we),
      .wr_addr (AW'(req_oam_index[7:2])),
      .wr_lane (req_oam_index[1:0]),
      .wr_data (req_oam_data),
      .rd_addr (scan_addr_ff[AW-1:0]),
      .rd_data (mem_rdata)
   );

   lcdt_line_sel #(
      .MAX_LINE_SPRITES (MAX_LINE_SPRITES),
      .CW               (CW),
      .SW               (SW)
   ) u_line_sel (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .ins_entry (mem_rdata),
      .line      (line_ff),
      .height    (height_ff),
      .rd_idx    (idx_ff),
      .count     (sel_count),
      .rd_entry  (sel_entry)
   );

   // Sprite burst length and drawing penalty follow from the selected count.
   assign n_emit   = (sel_count > CW'(NCAP)) ? CW'(NCAP) : sel_count;
   assign pen_full = 8'(sel_count) * 8'(lcdt_pkg::SPRITE_DOTS);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcdt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      dot_in       = dot_ff;
      mode_in      = mode_ff;
      line_in      = line_ff;
      match_in     = match_ff;
      win_in       = win_ff;
      pen_in       = pen_ff;
      rsp_valid_in = rsp_valid_ff;
      vb_in        = vb_ff;
      st_in        = st_ff;
      fd_in        = fd_ff;
      spv_in       = spv_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      scan_addr_in = scan_addr_ff;
      pend_in      = 1'b0;
      scan_ctl     = '0;
      dot_next     = dot_ff + 9'd1;
      line_next    = line_ff + 8'd1;
      win_step     = req_window_visible && (line_ff >= wtop_ff) &&
                     (10'(line_ff) < 10'(wtop_ff) + 10'(VISIBLE_LINES));

      case (state_ff)
         lcdt_pkg::ST_IDLE: begin
            if (rsp_valid_ff && !rsp_stall) begin
               rsp_valid_in = 1'b0;
            end
            if (accept) begin
               rsp_valid_in = 1'b1;
               vb_in        = 1'b0;
               st_in        = 1'b0;
               fd_in        = 1'b0;
               spv_in       = 1'b0;
               last_in      = 1'b1;
               if (req_mode == lcdt_pkg::OP_DOT) begin
                  dot_in = dot_next;
                  case (mode_ff)
                     lcdt_pkg::MODE_SCAN: begin
                        // The scan runs on the first dot; the response waits for it.
                        if (dot_next == 9'd1) begin
                           scan_ctl.clear = 1'b1;
                           scan_addr_in   = '0;
                           state_in       = lcdt_pkg::ST_SCAN;
                           rsp_valid_in   = 1'b0;
                        end
                        if (dot_next >= 9'(SCAN_DOTS)) begin
                           mode_in = lcdt_pkg::MODE_DRAW;
                           pen_in  = (pen_full > 8'(lcdt_pkg::PENALTY_MAX)) ?
                                     6'(lcdt_pkg::PENALTY_MAX) : pen_full[5:0];
                           if (n_emit != '0) begin
                              spv_in  = 1'b1;
                              idx_in  = '0;
                              last_in = (n_emit == CW'(1));
                              if (n_emit != CW'(1)) begin
                                 state_in = lcdt_pkg::ST_EMIT;
                              end
                           end
                        end
                     end
                     lcdt_pkg::MODE_DRAW: begin
                        if (req_pixels_done) begin
                           if (pen_ff != 6'd0) begin
                              pen_in = pen_ff - 6'd1;
                           end else begin
                              mode_in = lcdt_pkg::MODE_HBLANK;
                              st_in   = stat_hblank_ff;
                           end
                        end
                     end
                     lcdt_pkg::MODE_HBLANK: begin
                        if (dot_next >= 9'(DOTS_PER_LINE)) begin
                           if (win_step) begin
                              win_in = win_ff + 8'd1;
                           end
                           line_in  = line_next;
                           match_in = (line_next == lyc_ff);
                           st_in    = match_in && stat_match_ff;
                           if (line_next >= 8'(VISIBLE_LINES)) begin
                              mode_in = lcdt_pkg::MODE_VBLANK;
                              vb_in   = 1'b1;
                              fd_in   = 1'b1;
                              if (stat_vblank_ff) begin
                                 st_in = 1'b1;
                              end
                           end else begin
                              mode_in = lcdt_pkg::MODE_SCAN;
                           end
                           dot_in = 9'd0;
                        end
                     end
                     default: begin
                        if (dot_next >= 9'(DOTS_PER_LINE)) begin
                           if (win_step) begin
                              win_in = win_ff + 8'd1;
                           end
                           line_in  = line_next;
                           match_in = (line_next == lyc_ff);
                           st_in    = match_in && stat_match_ff;
                           // The compare above still sees the line past the frame.
                           if (line_next >= 8'(FRAME_LINES)) begin
                              mode_in = lcdt_pkg::MODE_SCAN;
                              line_in = 8'd0;
                              win_in  = 8'd0;
                           end
                           dot_in = 9'd0;
                        end
                     end
                  endcase
               end
            end
         end
         lcdt_pkg::ST_SCAN: begin
            scan_ctl.load = pend_ff;
            pend_in       = issue;
            if (issue) begin
               scan_addr_in = scan_addr_ff + (AW+1)'(1);
            end else if (!pend_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = lcdt_pkg::ST_IDLE;
            end
         end
         lcdt_pkg::ST_EMIT: begin
            if (!rsp_stall) begin
               idx_in  = idx_ff + SW'(1);
               last_in = (CW'(idx_ff) + CW'(2) == n_emit);
               if (last_in) begin
                  state_in = lcdt_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = lcdt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff       <= 9'd0;
         mode_ff      <= lcdt_pkg::MODE_SCAN;
         line_ff      <= 8'd0;
         match_ff     <= 1'b0;
         win_ff       <= 8'd0;
         pen_ff       <= 6'd0;
         rsp_valid_ff <= 1'b0;
         scan_addr_ff <= '0;
         pend_ff      <= 1'b0;
      end else begin
         dot_ff       <= dot_in;
         mode_ff      <= mode_in;
         line_ff      <= line_in;
         match_ff     <= match_in;
         win_ff       <= win_in;
         pen_ff       <= pen_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_addr_ff <= scan_addr_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      vb_ff   <= vb_in;
      st_ff   <= st_in;
      fd_ff   <= fd_in;
      spv_ff  <= spv_in;
      last_ff <= last_in;
      idx_ff  <= idx_in;
   end

   // Status fields come straight from the timing state, which cannot move while
   // a response is pending because requests are held off until it is taken.
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_lcd_mode       = mode_ff;
   assign rsp_line_count     = line_ff;
   assign rsp_match_flag     = match_ff;
   assign rsp_vblank_request = vb_ff;
   assign rsp_stat_request   = st_ff;
   assign rsp_frame_done     = fd_ff;
   assign rsp_window_line    = win_ff;
   assign rsp_sprite_valid   = spv_ff;
   assign rsp_sprite_entry   = spv_ff ? sel_entry : 32'd0;
   assign rsp_sprite_count   = 4'(sel_count);
   assign rsp_last           = last_ff;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Testbench for the display line timing block with object memory sprite scan.
`timescale 1ns / 1ps

import lcdt_pkg::*;

typedef struct {
   logic [1:0]  lcd_mode;
   logic [7:0]  line_count;
   logic        match_flag;
   logic        vblank_request;
   logic        stat_request;
   logic        frame_done;
   logic [7:0]  window_line;
   logic        sprite_valid;
   logic [31:0] sprite_entry;
   logic [3:0]  sprite_count;
   logic        last;
} lcd_status_type;

// The scoreboard holds a behavioral copy of the line timing state and a queue of
// the status responses that each accepted request is owed.
class lcd_timing_scoreboard;
   logic [31:0] objects[OAM_ENTRIES_DEF];
   logic [31:0] picked[MAX_LINE_SPRITES_DEF];
   int unsigned picked_count;
   int unsigned dot;
   logic [1:0]  lcd_mode;
   logic [7:0]  line;
   logic        match;
   logic [7:0]  window_line;
   int unsigned penalty;
   logic [7:0]  line_compare;
   logic        stat_on_match, stat_on_hblank, stat_on_vblank;
   logic [4:0]  sprite_height;
   logic [7:0]  window_top;
   lcd_status_type owed[$];
   int errors;
   int responses;
   int sprite_responses;

   function void clear();
      foreach (objects[i]) objects[i] = '0;
      foreach (picked[i]) picked[i] = '0;
      picked_count = 0;
      dot = 0;
      lcd_mode = MODE_SCAN;
      line = 0;
      match = 0;
      window_line = 0;
      penalty = 0;
      line_compare = 0;
      stat_on_match = 0;
      stat_on_hblank = 0;
      stat_on_vblank = 0;
      sprite_height = 8;
      window_top = 0;
      owed.delete();
      errors = 0;
      responses = 0;
      sprite_responses = 0;
   endfunction

   function void write_register(logic [2:0] index, logic [7:0] value);
      case (index)
         CSR_LINE_COMPARE:   line_compare = value;
         CSR_STAT_ON_MATCH:  stat_on_match = value[0];
         CSR_STAT_ON_HBLANK: stat_on_hblank = value[0];
         CSR_STAT_ON_VBLANK: stat_on_vblank = value[0];
         CSR_SPRITE_HEIGHT:  sprite_height = value[4:0];
         CSR_WINDOW_TOP:     window_top = value;
         default: ;
      endcase
   endfunction

   // Collects the objects covering the current line, in X order, OAM order on ties.
   function void pick_sprites();
      int unsigned target, y, x, pos;
      target = line + Y_OFFSET;
      picked_count = 0;
      for (int i = 0; i < OAM_ENTRIES_DEF; i++) begin
         if (picked_count >= MAX_LINE_SPRITES_DEF) break;
         y = objects[i][7:0];
         x = objects[i][15:8];
         if (!(y <= target && y + sprite_height > target)) continue;
         pos = 0;
         while (pos < picked_count && picked[pos][15:8] <= x) pos++;
         for (int j = picked_count; j > pos; j--) picked[j] = picked[j-1];
         picked[pos] = objects[i];
         picked_count++;
      end
   endfunction

   function logic advance_line(logic window_shown);
      if (window_shown && line >= window_top && int'(line) < int'(window_top) + 144)
         window_line = window_line + 8'd1;
      line = line + 8'd1;
      match = (line == line_compare);
      return match && stat_on_match;
   endfunction

   function void note_request(logic op, logic [7:0] index, logic [7:0] data,
                              logic pixels_done, logic window_shown);
      logic vb, st, fd, emit;
      lcd_status_type r;
      int unsigned n;
      vb = 0; st = 0; fd = 0; emit = 0;
      if (op == OP_OAM_WRITE) begin
         if (index < OAM_ENTRIES_DEF * 4)
            objects[index >> 2][(index & 3) * 8 +: 8] = data;
      end else begin
         dot = (dot + 1) & 9'h1ff;
         case (lcd_mode)
            MODE_SCAN: begin
               if (dot == 1) pick_sprites();
               if (dot >= SCAN_DOTS_DEF) begin
                  lcd_mode = MODE_DRAW;
                  penalty = picked_count * SPRITE_DOTS;
                  if (penalty > PENALTY_MAX) penalty = PENALTY_MAX;
                  emit = 1;
               end
            end
            MODE_DRAW: begin
               if (pixels_done) begin
                  if (penalty > 0) penalty--;
                  else begin
                     lcd_mode = MODE_HBLANK;
                     if (stat_on_hblank) st = 1;
                  end
               end
            end
            MODE_HBLANK: begin
               if (dot >= DOTS_PER_LINE_DEF) begin
                  if (advance_line(window_shown)) st = 1;
                  if (line >= VISIBLE_LINES_DEF) begin
                     lcd_mode = MODE_VBLANK;
                     vb = 1;
                     fd = 1;
                     if (stat_on_vblank) st = 1;
                  end else lcd_mode = MODE_SCAN;
                  dot = 0;
               end
            end
            default: begin
               if (dot >= DOTS_PER_LINE_DEF) begin
                  if (advance_line(window_shown)) st = 1;
                  if (line >= FRAME_LINES_DEF) begin
                     lcd_mode = MODE_SCAN;
                     line = 0;
                     window_line = 0;
                  end
                  dot = 0;
               end
            end
         endcase
      end
      r.lcd_mode = lcd_mode;
      r.line_count = line;
      r.match_flag = match;
      r.vblank_request = vb;
      r.stat_request = st;
      r.frame_done = fd;
      r.window_line = window_line;
      r.sprite_count = picked_count[3:0];
      n = (emit && picked_count > 0) ? picked_count : 0;
      if (n == 0) begin
         r.sprite_valid = 0;
         r.sprite_entry = '0;
         r.last = 1;
         owed.push_back(r);
      end else begin
         for (int k = 0; k < n; k++) begin
            r.sprite_valid = 1;
            r.sprite_entry = picked[k];
            r.last = (k == n - 1);
            owed.push_back(r);
         end
      end
   endfunction

   function void report(string what, logic [31:0] seen, logic [31:0] want);
      errors++;
      $display("mismatch on %s: got %0h, expected %0h (response %0d)",
               what, seen, want, responses);
   endfunction

   function void check_response(lcd_status_type got);
      lcd_status_type w;
      responses++;
      if (owed.size() == 0) begin
         errors++;
         $display("unexpected response %0d", responses);
         return;
      end
      w = owed.pop_front();
      if (got.sprite_valid) sprite_responses++;
      if (got.lcd_mode !== w.lcd_mode) report("lcd_mode", got.lcd_mode, w.lcd_mode);
      if (got.line_count !== w.line_count)
         report("line_count", got.line_count, w.line_count);
      if (got.match_flag !== w.match_flag)
         report("match_flag", got.match_flag, w.match_flag);
      if (got.vblank_request !== w.vblank_request)
         report("vblank_request", got.vblank_request, w.vblank_request);
      if (got.stat_request !== w.stat_request)
         report("stat_request", got.stat_request, w.stat_request);
      if (got.frame_done !== w.frame_done)
         report("frame_done", got.frame_done, w.frame_done);
      if (got.window_line !== w.window_line)
         report("window_line", got.window_line, w.window_line);
      if (got.sprite_valid !== w.sprite_valid)
         report("sprite_valid", got.sprite_valid, w.sprite_valid);
      if (got.sprite_entry !== w.sprite_entry)
         report("sprite_entry", got.sprite_entry, w.sprite_entry);
      if (got.sprite_count !== w.sprite_count)
         report("sprite_count", got.sprite_count, w.sprite_count);
      if (got.last !== w.last) report("last", got.last, w.last);
   endfunction
endclass

module tb;
   // About 320 requests, one full OAM scan and a few drains stay far below this
   // limit even under heavy stalling.
   localparam int CYCLE_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_mode = OP_DOT;
   logic [7:0]  req_oam_index = '0;
   logic [7:0]  req_oam_data = '0;
   logic        req_pixels_done = 0;
   logic        req_window_visible = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_lcd_mode;
   logic [7:0]  rsp_line_count;
   logic        rsp_match_flag;
   logic        rsp_vblank_request;
   logic        rsp_stat_request;
   logic        rsp_frame_done;
   logic [7:0]  rsp_window_line;
   logic        rsp_sprite_valid;
   logic [31:0] rsp_sprite_entry;
   logic [3:0]  rsp_sprite_count;
   logic        rsp_last;

   lcd_timing_scoreboard board;
   int  cycle_count = 0;
   int  requests_sent = 0;
   bit  calm_stretch = 0;   // while set, neither side idles

   always #4 clock = ~clock;

   lcd_mode_timing_with_oam_scan dut (.*);

   // The cycle counter stops a hung run with the fail message.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[lcd_mode_timing_with_oam_scan] ERROR");
         $finish;
      end
   end

   // The response side stalls about 37 times in a hundred except in calm stretches,
   // and every response taken is compared with the oldest one owed.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            lcd_status_type got;
            got.lcd_mode = rsp_lcd_mode;
            got.line_count = rsp_line_count;
            got.match_flag = rsp_match_flag;
            got.vblank_request = rsp_vblank_request;
            got.stat_request = rsp_stat_request;
            got.frame_done = rsp_frame_done;
            got.window_line = rsp_window_line;
            got.sprite_valid = rsp_sprite_valid;
            got.sprite_entry = rsp_sprite_entry;
            got.sprite_count = rsp_sprite_count;
            got.last = rsp_last;
            board.check_response(got);
         end
         rsp_stall <= calm_stretch ? 1'b0 : ($urandom_range(99) < 37);
      end
   end

   // Sends one request, with a random idle gap first, and notes it once accepted.
   // Valid stays high afterwards; the next request or a pause takes it down.
   task automatic send_request(logic op, logic [7:0] index, logic [7:0] data,
                               logic pixels_done, logic window_shown);
      if (!calm_stretch) begin
         while ($urandom_range(99) < 37) begin
            req_valid <= 0;
            @(posedge clock);
         end
      end
      req_valid <= 1;
      req_mode <= op;
      req_oam_index <= index;
      req_oam_data <= data;
      req_pixels_done <= pixels_done;
      req_window_visible <= window_shown;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(op, index, data, pixels_done, window_shown);
      requests_sent++;
   endtask

   task automatic hold_requests();
      req_valid <= 0;
   endtask

   task automatic dot_tick(logic pixels_done, logic window_shown);
      send_request(OP_DOT, 8'($urandom), 8'($urandom), pixels_done, window_shown);
   endtask

   task automatic oam_write(logic [7:0] index, logic [7:0] data);
      send_request(OP_OAM_WRITE, index, data, 1'($urandom), 1'($urandom));
   endtask

   // Writes one object entry of four bytes: y, x, tile and flags.
   task automatic place_object(int slot, logic [7:0] y, logic [7:0] x);
      oam_write(8'(slot * 4), y);
      oam_write(8'(slot * 4 + 1), x);
      oam_write(8'(slot * 4 + 2), 8'($urandom));
      oam_write(8'(slot * 4 + 3), 8'($urandom));
   endtask

   // Waits until nothing is owed, then lets the scan latency pass so the block is
   // idle before a register write.
   task automatic drain();
      hold_requests();
      while (board.owed.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_register(logic [2:0] index, logic [7:0] value);
      csr_valid <= 1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_register(index, value);
   endtask

   task automatic configure(logic [7:0] compare, logic [2:0] stat_bits,
                            logic [4:0] height, logic [7:0] top);
      drain();
      write_register(CSR_LINE_COMPARE, compare);
      write_register(CSR_STAT_ON_MATCH, 8'(stat_bits[0]));
      write_register(CSR_STAT_ON_HBLANK, 8'(stat_bits[1]));
      write_register(CSR_STAT_ON_VBLANK, 8'(stat_bits[2]));
      write_register(CSR_SPRITE_HEIGHT, 8'(height));
      write_register(CSR_WINDOW_TOP, top);
      csr_valid <= 0;
   endtask

   // Drives dots with random fetcher flags; done is mostly high so drawing ends.
   task automatic run_dots(int count, int done_percent);
      repeat (count) dot_tick($urandom_range(99) < done_percent, 1'($urandom));
   endtask

   initial begin
      board = new();
      board.clear();
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: twelve tall objects cover line 0, so the list overflows
      // and is clipped to ten; X values repeat in groups of four to force ties.
      configure(8'd1, 3'b111, 5'd16, 8'd0);
      for (int s = 0; s < 12; s++) begin
         place_object(s, 8'(16 - (s % 3)), 8'(40 + 8 * (s / 4)));
      end
      // Two objects just above and just below the line are skipped.
      place_object(12, 8'd0, 8'd20);
      place_object(13, 8'd17, 8'd20);
      // Writes past the end of object memory are ignored; the last byte is kept.
      oam_write(8'd160, 8'hff);
      oam_write(8'd255, 8'h00);
      oam_write(8'd159, 8'hff);

      // Pause the sender until every owed response has come back.
      hold_requests();
      while (board.owed.size() != 0) @(posedge clock);

      // A calm stretch without idling on either side runs the scan, the sprite
      // burst and the start of drawing.
      calm_stretch = 1;
      run_dots(100, 90);
      calm_stretch = 0;

      // Random part: mostly dots through drawing and horizontal blank, with some
      // OAM writes in between.
      repeat (160) begin
         if ($urandom_range(99) < 10) oam_write(8'($urandom_range(0, 170)), 8'($urandom));
         else dot_tick($urandom_range(99) < 90, 1'($urandom));
      end

      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d requests, %0d responses, %0d with a sprite entry",
               requests_sent, board.responses, board.sprite_responses);
      $display("through a crowded OAM scan, the sprite burst, drawing and hblank");
      if (board.errors == 0 && board.owed.size() == 0) begin
         $display("[lcd_mode_timing_with_oam_scan] OK");
      end else begin
         $display("[lcd_mode_timing_with_oam_scan] ERROR");
      end
      $finish;
   end
endmodule
